// ===== rtl/fp8dp_pkg.sv =====
package fp8dp_pkg;
    localparam int WORD_W = 32;
    localparam int LANE_W = 8;
    localparam int LANES_DEF = 4;
    localparam int LANES_MAX = 8;
    localparam int PROD_W = 36;
    localparam int ACC_W = 40;
    localparam int MAG_W = 39;
    localparam int SIG_BITS = 24;
    localparam int UNIT_EXP = 18;
    localparam logic [3:0] EXP_MASK = 4'hf;
    localparam logic [2:0] MAN_MASK = 3'h7;

    typedef logic [LANE_W-1:0] t_fp8;

    function automatic logic [5:0] bit_len(input logic [MAG_W-1:0] u);
        logic [5:0] n;
        n = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (u[k]) begin
                n = 6'(k + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [MAG_W-1:0] round_mag(input logic [MAG_W-1:0] u);
        logic [5:0] len;
        logic [5:0] s;
        logic [MAG_W-1:0] mask;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] half;
        logic [MAG_W-1:0] q;
        len = bit_len(u);
        if (len <= 6'(SIG_BITS)) begin
            return u;
        end
        s = len - 6'(SIG_BITS);
        mask = (MAG_W'(1) << s) - MAG_W'(1);
        rem = u & mask;
        half = MAG_W'(1) << (s - 6'd1);
        q = u >> s;
        if (rem > half || (rem == half && q[0])) begin
            q = q + MAG_W'(1);
        end
        return q << s;
    endfunction
endpackage

// ===== rtl/fp8dp_if.sv =====
interface fp8dp_if #(parameter int W = 32);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/fp8dp_in_if.sv =====
interface fp8dp_in_if;
    logic valid;
    logic ready;
    logic [fp8dp_pkg::WORD_W-1:0] a_lanes;
    logic [fp8dp_pkg::WORD_W-1:0] b_lanes;
    modport source(output valid, output a_lanes, output b_lanes, input ready);
    modport sink(input valid, input a_lanes, input b_lanes, output ready);
endinterface

// ===== rtl/fp8dp_lane_mul.sv =====
module fp8dp_lane_mul (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  fp8dp_pkg::t_fp8                 i_a,
    input  fp8dp_pkg::t_fp8                 i_b,
    output logic signed [fp8dp_pkg::ACC_W-1:0] o_prod
);
    logic [3:0] ea, eb;
    logic [3:0] sa, sb;
    logic [3:0] sha, shb;
    logic [7:0] sig_p;
    logic [fp8dp_pkg::PROD_W-1:0] mag;
    logic signed [fp8dp_pkg::ACC_W-1:0] n_prod;
    logic signed [fp8dp_pkg::ACC_W-1:0] r_prod;

    always_comb begin
        ea = i_a[6:3] & fp8dp_pkg::EXP_MASK;
        eb = i_b[6:3] & fp8dp_pkg::EXP_MASK;
        sa = (ea == 4'd0) ? {1'b0, i_a[2:0] & fp8dp_pkg::MAN_MASK} : {1'b1, i_a[2:0]};
        sb = (eb == 4'd0) ? {1'b0, i_b[2:0] & fp8dp_pkg::MAN_MASK} : {1'b1, i_b[2:0]};
        sha = (ea == 4'd0) ? 4'd0 : ea - 4'd1;
        shb = (eb == 4'd0) ? 4'd0 : eb - 4'd1;
        sig_p = sa * sb;
        mag = fp8dp_pkg::PROD_W'(sig_p) << (5'(sha) + 5'(shb));
        n_prod = (i_a[7] ^ i_b[7]) ? -$signed({4'd0, mag}) : $signed({4'd0, mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;
endmodule

// ===== rtl/fp8dp_acc_step.sv =====
module fp8dp_acc_step (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [fp8dp_pkg::ACC_W-1:0]  i_acc,
    input  logic signed [fp8dp_pkg::ACC_W-1:0]  i_prod,
    output logic signed [fp8dp_pkg::ACC_W-1:0]  o_acc
);
    logic signed [fp8dp_pkg::ACC_W-1:0] sum;
    logic [fp8dp_pkg::MAG_W-1:0] mag;
    logic [fp8dp_pkg::MAG_W-1:0] rmag;
    logic signed [fp8dp_pkg::ACC_W-1:0] n_acc;
    logic signed [fp8dp_pkg::ACC_W-1:0] r_acc;

    always_comb begin
        sum = i_acc + i_prod;
        mag = sum[fp8dp_pkg::ACC_W-1] ? fp8dp_pkg::MAG_W'(-sum)
                                      : fp8dp_pkg::MAG_W'(sum);
        rmag = fp8dp_pkg::round_mag(mag);
        n_acc = sum[fp8dp_pkg::ACC_W-1] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

// ===== rtl/fp8_four_lane_dot_product.sv =====
// each lane has its own multiplier and rounded add register; lane multipliers work in parallel
// throughput: one word per cycle unless stalled, one add stage per lane
// the pipeline advances whenever its output register is empty or being taken
// reset: synchronous active-low i_rst_n clears all valid flags, payload is not reset
module fp8_four_lane_dot_product #(
    parameter int LANES = fp8dp_pkg::LANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fp8dp_in_if.sink    i_in,
    fp8dp_if.source     o_out
);
    localparam int ST = LANES + 3;

    logic adv;
    logic [ST-1:0] r_vld;
    logic [fp8dp_pkg::WORD_W-1:0] r_a [LANES];
    logic [fp8dp_pkg::WORD_W-1:0] r_b [LANES];
    logic signed [fp8dp_pkg::ACC_W-1:0] prod [LANES];
    logic signed [fp8dp_pkg::ACC_W-1:0] acc [LANES+1];
    logic [fp8dp_pkg::MAG_W-1:0] fmag;
    logic [5:0] len;
    logic [fp8dp_pkg::MAG_W-1:0] mant;
    logic [7:0] bexp;
    logic [31:0] n_res;
    logic [31:0] r_res;

    assign adv = !r_vld[ST-1] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[ST-2:0], i_in.valid};
        end
    end

    // lane operands delayed so lane k multiplies one stage before its add
    genvar k;
    generate
        for (k = 0; k < LANES; k++) begin : g_lane
            if (k == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_a[0] <= i_in.a_lanes;
                        r_b[0] <= i_in.b_lanes;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (adv) begin
                        r_a[k] <= r_a[k-1];
                        r_b[k] <= r_b[k-1];
                    end
                end
            end
            fp8dp_lane_mul u_mul (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_a   ((k < 4) ? r_a[k][(k%4)*8 +: 8] : 8'd0),
                .i_b   ((k < 4) ? r_b[k][(k%4)*8 +: 8] : 8'd0),
                .o_prod(prod[k])
            );
            fp8dp_acc_step u_add (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_acc (acc[k]),
                .i_prod(prod[k]),
                .o_acc (acc[k+1])
            );
        end
    endgenerate

    assign acc[0] = '0;

    always_comb begin
        fmag = acc[LANES][fp8dp_pkg::ACC_W-1] ? fp8dp_pkg::MAG_W'(-acc[LANES])
                                             : fp8dp_pkg::MAG_W'(acc[LANES]);
        len = fp8dp_pkg::bit_len(fmag);
        if (len > 6'(fp8dp_pkg::SIG_BITS)) begin
            mant = fmag >> (len - 6'(fp8dp_pkg::SIG_BITS));
        end else begin
            mant = fmag << (6'(fp8dp_pkg::SIG_BITS) - len);
        end
        bexp = 8'(len) + 8'(127 - 1 - fp8dp_pkg::UNIT_EXP);
        if (fmag == '0) begin
            n_res = '0;
        end else begin
            n_res = {acc[LANES][fp8dp_pkg::ACC_W-1], bexp, mant[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid = r_vld[ST-1];
    assign o_out.data  = r_res;
endmodule
